// ----- rtl/core/sem_pkg.sv -----
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants for the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sem_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	localparam int CFG_W  = 11;
	localparam int PIX_W  = 8;
	localparam int GRAD_W = 10;
	localparam int MAG_W  = 8;

	localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd480;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} cfg_reg_t;

	// absolute gradients of one interior pixel
	typedef struct packed {
		logic [GRAD_W-1:0] ax;
		logic [GRAD_W-1:0] ay;
		logic              last;
	} grad_t;

endpackage

// ----- rtl/core/sem_if.sv -----
// ----------------------------------------------------------------------------
// sem_if
// Stream interfaces for pixel requests and magnitude results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sem_pixel_if;
	logic                       valid;
	logic                       ready;
	logic [sem_pkg::PIX_W-1:0]  pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

interface sem_result_if;
	logic                       valid;
	logic                       ready;
	logic [sem_pkg::MAG_W-1:0]  magnitude;
	logic                       frame_last;

	modport source (output valid, output magnitude, output frame_last, input ready);
	modport sink   (input valid, input magnitude, input frame_last, output ready);
endinterface

// ----- rtl/core/sem_window.sv -----
// ----------------------------------------------------------------------------
// sem_window
// Raster position counters, the two-row line store and the 3x3 window;
// forms the absolute Sobel gradients of every interior pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sem_window #(
	parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       restart,
	input  logic [sem_pkg::CFG_W-1:0]  width,
	input  logic [sem_pkg::CFG_W-1:0]  height,
	input  logic                       pix_valid,
	output logic                       pix_ready,
	input  logic [sem_pkg::PIX_W-1:0]  pix,
	output logic                       grad_valid,
	input  logic                       grad_ready,
	output sem_pkg::grad_t             grad
);

	localparam int CFG_W  = sem_pkg::CFG_W;
	localparam int PIX_W  = sem_pkg::PIX_W;
	localparam int GRAD_W = sem_pkg::GRAD_W;
	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int RW     = $clog2(MAX_HEIGHT);

	typedef logic [2:0][PIX_W-1:0] column_t;

	logic [CW-1:0]        col_q, col_last, col_s1;
	logic [RW-1:0]        row_q, row_last;
	logic                 acc, s1_go;
	logic                 s1_valid_q, grad_valid_q;
	logic [PIX_W-1:0]     pix_s1;
	logic                 emit_s1, last_s1;
	logic [2*PIX_W-1:0]   rd_s1;
	logic [2*PIX_W-1:0]   line_mem [MAX_WIDTH];
	column_t              win_q [2];
	logic [PIX_W-1:0]     nt, nm;
	logic [GRAD_W-1:0]    gx_p, gx_n, gy_p, gy_n;
	sem_pkg::grad_t       grad_d, grad_s2;

	// clamp configured size to the supported range
	always_comb begin
		if (width < CFG_W'(3))
			col_last = CW'(2);
		else if (32'(width) > MAX_WIDTH)
			col_last = CW'(MAX_WIDTH - 1);
		else
			col_last = CW'(width - CFG_W'(1));
		if (height < CFG_W'(3))
			row_last = RW'(2);
		else if (32'(height) > MAX_HEIGHT)
			row_last = RW'(MAX_HEIGHT - 1);
		else
			row_last = RW'(height - CFG_W'(1));
	end

	assign s1_go     = s1_valid_q && (!grad_valid_q || grad_ready);
	assign pix_ready = !s1_valid_q || s1_go;
	assign acc       = pix_valid && pix_ready;

	// line store entry: [15:8] two rows up, [7:0] one row up
	always_ff @(posedge clk) begin
		if (acc)
			rd_s1 <= line_mem[col_q];
		if (s1_go)
			line_mem[col_s1] <= {rd_s1[PIX_W-1:0], pix_s1};
	end

	assign nt = rd_s1[2*PIX_W-1:PIX_W];
	assign nm = rd_s1[PIX_W-1:0];

	always_comb begin
		gx_p = {2'b00, nt} + {1'b0, nm, 1'b0} + {2'b00, pix_s1};
		gx_n = {2'b00, win_q[0][0]} + {1'b0, win_q[0][1], 1'b0} + {2'b00, win_q[0][2]};
		gy_p = {2'b00, win_q[0][2]} + {1'b0, win_q[1][2], 1'b0} + {2'b00, pix_s1};
		gy_n = {2'b00, win_q[0][0]} + {1'b0, win_q[1][0], 1'b0} + {2'b00, nt};
		grad_d.ax   = (gx_p >= gx_n) ? gx_p - gx_n : gx_n - gx_p;
		grad_d.ay   = (gy_p >= gy_n) ? gy_p - gy_n : gy_n - gy_p;
		grad_d.last = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q        <= '0;
			row_q        <= '0;
			s1_valid_q   <= 1'b0;
			grad_valid_q <= 1'b0;
			win_q[0]     <= '0;
			win_q[1]     <= '0;
		end else begin
			if (restart) begin
				col_q <= '0;
				row_q <= '0;
			end else if (acc) begin
				if (col_q == col_last) begin
					col_q <= '0;
					row_q <= (row_q == row_last) ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (acc)
				s1_valid_q <= 1'b1;
			else if (s1_go)
				s1_valid_q <= 1'b0;
			if (s1_go)
				grad_valid_q <= emit_s1;
			else if (grad_ready)
				grad_valid_q <= 1'b0;
			if (s1_go) begin
				win_q[0] <= win_q[1];
				win_q[1] <= {pix_s1, nm, nt};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			col_s1  <= col_q;
			pix_s1  <= pix;
			emit_s1 <= (row_q >= RW'(2)) && (col_q >= CW'(2));
			last_s1 <= (row_q == row_last) && (col_q == col_last);
		end
		if (s1_go)
			grad_s2 <= grad_d;
	end

	assign grad_valid = grad_valid_q;
	assign grad       = grad_s2;

	a_restart_clears: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> (col_q == '0) && (row_q == '0))
		else $error("position not cleared after register write");

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= col_last) && (row_q <= row_last))
		else $error("position outside frame");

	a_last_interior: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && last_s1 |-> emit_s1)
		else $error("frame end flagged on border pixel");

	a_emit_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && emit_s1 |=> grad_valid_q)
		else $error("interior pixel dropped");

endmodule

// ----- rtl/core/sem_magnitude.sv -----
// ----------------------------------------------------------------------------
// sem_magnitude
// Squares and sums the gradients, then a two-stage digit-by-digit
// integer square root, saturated at 255.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sem_magnitude (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       grad_valid,
	output logic                       grad_ready,
	input  sem_pkg::grad_t             grad,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic [sem_pkg::MAG_W-1:0]  magnitude,
	output logic                       frame_last
);

	localparam int GRAD_W = sem_pkg::GRAD_W;
	localparam int MAG_W  = sem_pkg::MAG_W;
	localparam int SQ_W   = 2 * GRAD_W;

	typedef struct packed {
		logic [11:0]      rem;
		logic [MAG_W-1:0] root;
	} root_t;

	function automatic root_t sqrt_step(input root_t st, input logic [1:0] pair);
		root_t       nx;
		logic [11:0] r;
		logic [11:0] trial;
		r     = {st.rem[9:0], pair};
		trial = {2'b00, st.root, 2'b01};
		if (r >= trial) begin
			nx.rem  = r - trial;
			nx.root = {st.root[MAG_W-2:0], 1'b1};
		end else begin
			nx.rem  = r;
			nx.root = {st.root[MAG_W-2:0], 1'b0};
		end
		return nx;
	endfunction

	logic               v1_q, v2_q, v3_q;
	logic               rdy1, rdy2, rdy3;
	logic [SQ_W-1:0]    sqx_s1, sqy_s1;
	logic               last_s1, last_s2, last_s3;
	logic [SQ_W:0]      sum;
	root_t              hi_d, lo_d, st_s2;
	logic [7:0]         low_s2;
	logic               sat_s2;
	logic [MAG_W-1:0]   mag_s3;

	assign rdy3       = !v3_q || res_ready;
	assign rdy2       = !v2_q || rdy3;
	assign rdy1       = !v1_q || rdy2;
	assign grad_ready = rdy1;

	always_comb begin
		sum  = {1'b0, sqx_s1} + {1'b0, sqy_s1};
		hi_d = '0;
		for (int i = 0; i < 4; i++)
			hi_d = sqrt_step(hi_d, sum[15 - 2*i -: 2]);
		lo_d = st_s2;
		for (int i = 0; i < 4; i++)
			lo_d = sqrt_step(lo_d, low_s2[7 - 2*i -: 2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
		end else begin
			if (rdy1)
				v1_q <= grad_valid;
			if (rdy2)
				v2_q <= v1_q;
			if (rdy3)
				v3_q <= v2_q;
		end
	end

	always_ff @(posedge clk) begin
		if (grad_valid && rdy1) begin
			sqx_s1  <= SQ_W'(grad.ax) * SQ_W'(grad.ax);
			sqy_s1  <= SQ_W'(grad.ay) * SQ_W'(grad.ay);
			last_s1 <= grad.last;
		end
		if (v1_q && rdy2) begin
			st_s2   <= hi_d;
			low_s2  <= sum[7:0];
			sat_s2  <= |sum[SQ_W:16];
			last_s2 <= last_s1;
		end
		if (v2_q && rdy3) begin
			mag_s3  <= sat_s2 ? {MAG_W{1'b1}} : lo_d.root;
			last_s3 <= last_s2;
		end
	end

	assign res_valid  = v3_q;
	assign magnitude  = mag_s3;
	assign frame_last = last_s3;

endmodule

// ----- rtl/core/sobel_edge_magnitude_top.sv -----
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_top
// Sobel 3x3 gradient magnitude over a raster stream of 8-bit pixels.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one request per clock while the output does
// not stall; each interior pixel yields floor(sqrt(gx^2+gy^2)) saturated at
// 255, and border pixels yield nothing. The result for pixel (r-1, c-1) is
// formed when pixel (r, c) arrives, then registered and passed through the
// magnitude stages. The line store sets the rate: one synchronous read per
// pixel, the entry written back as that pixel leaves the input register.
// Width and height clamp to [3, MAX_WIDTH] and [3, MAX_HEIGHT]; any register
// write restarts the frame at row 0, column 0. Line store contents are not
// cleared after reset and only feed results once two rows have been written.
`timescale 1ns / 1ps

module sobel_edge_magnitude_top #(
	parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [sem_pkg::CFG_W-1:0]  cfg_data,
	sem_pixel_if.sink                  pixel_in,
	sem_result_if.source               result_out
);

	logic [sem_pkg::CFG_W-1:0] width_q, height_q;
	logic                      grad_valid, grad_ready;
	sem_pkg::grad_t            grad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sem_pkg::WIDTH_RST;
			height_q <= sem_pkg::HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (sem_pkg::cfg_reg_t'(cfg_index))
				sem_pkg::REG_WIDTH:  width_q  <= cfg_data;
				sem_pkg::REG_HEIGHT: height_q <= cfg_data;
			endcase
		end
	end

	sem_window #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.restart    (cfg_we),
		.width      (width_q),
		.height     (height_q),
		.pix_valid  (pixel_in.valid),
		.pix_ready  (pixel_in.ready),
		.pix        (pixel_in.pixel),
		.grad_valid (grad_valid),
		.grad_ready (grad_ready),
		.grad       (grad)
	);

	sem_magnitude u_magnitude (
		.clk        (clk),
		.arst_n     (arst_n),
		.grad_valid (grad_valid),
		.grad_ready (grad_ready),
		.grad       (grad),
		.res_valid  (result_out.valid),
		.res_ready  (result_out.ready),
		.magnitude  (result_out.magnitude),
		.frame_last (result_out.frame_last)
	);

endmodule

// ----- bench/sobel_edge_magnitude_top_test.sv -----
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_top_test
// Self-checking bench for the Sobel 3x3 edge magnitude stream block.
// ----------------------------------------------------------------------------
// Streams raster pixels through the pixel request channel under several
// frame sizes (clamped extremes included) and checks every magnitude result
// against an in-bench gradient predictor. A short table of hand-built frames
// comes first, then random frames under varied sender and receiver idling,
// a long receiver hold-off, and runs at the largest width and height.
`timescale 1ns / 1ps

module sobel_edge_magnitude_top_test;

	localparam int CFG_W       = sem_pkg::CFG_W;
	localparam int PIX_W       = sem_pkg::PIX_W;
	localparam int MAG_W       = sem_pkg::MAG_W;
	localparam int MAX_WIDTH   = sem_pkg::MAX_WIDTH_DEF;
	localparam int MAX_HEIGHT  = sem_pkg::MAX_HEIGHT_DEF;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE      = 16;
	localparam int NUM_ROWS    = 29;

	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		logic             frame_last;
	} sobel_result_t;

	typedef struct packed {
		bit                 is_write;
		sem_pkg::cfg_reg_t  reg_sel;
		logic [CFG_W-1:0]   value;
		bit                 typed;
		logic [MAG_W-1:0]   magnitude;
		logic               frame_last;
	} directed_row_t;

	// width 0 and height 2 both clamp to 3; three 3x3 frames follow
	localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
		'{1'b1, sem_pkg::REG_WIDTH,  11'd0,   1'b0, 8'd0,   1'b0},
		'{1'b1, sem_pkg::REG_HEIGHT, 11'd2,   1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd0,   1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd0,   1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd255, 1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd0,   1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd0,   1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd255, 1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd0,   1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd0,   1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd255, 1'b1, 8'd255, 1'b1},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd128, 1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd128, 1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd128, 1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd128, 1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd128, 1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd128, 1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd128, 1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd128, 1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd128, 1'b1, 8'd0,   1'b1},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd10,  1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd200, 1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd30,  1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd90,  1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd0,   1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd255, 1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd60,  1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd120, 1'b0, 8'd0,   1'b0},
		'{1'b0, sem_pkg::REG_WIDTH,  11'd5,   1'b0, 8'd0,   1'b0}
	};

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic             cfg_index;
	logic [CFG_W-1:0] cfg_data;

	sem_pixel_if  pix_bus ();
	sem_result_if res_bus ();

	sobel_edge_magnitude_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pixel_in   (pix_bus),
		.result_out (res_bus)
	);

	// predictor state
	logic [CFG_W-1:0] width_reg;
	logic [CFG_W-1:0] height_reg;
	logic [PIX_W-1:0] row_above_mem [MAX_WIDTH];
	logic [PIX_W-1:0] row_two_above_mem [MAX_WIDTH];
	logic [PIX_W-1:0] win_old [3];
	logic [PIX_W-1:0] win_new [3];
	int unsigned      col_pos;
	int unsigned      row_pos;

	sobel_result_t    expected_results [$];
	int               error_count;
	int               pixels_sent;
	int               results_checked;
	int               settings_used;
	int               cycle_count;
	int               idle_pct;
	int               stall_pct;
	int               hold_off_cycles;
	logic [PIX_W-1:0] last_pixel;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_results.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
		if (v < 3) return 3;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic [MAG_W-1:0] root_floor_sat(input int unsigned s);
		int unsigned r;
		int unsigned trial;
		if (s >= 65536) return 8'hFF;
		r = 0;
		for (int b = 7; b >= 0; b--) begin
			trial = r | (1 << b);
			if (trial * trial <= s) r = trial;
		end
		return r[MAG_W-1:0];
	endfunction

	function automatic logic [PIX_W-1:0] pick_pixel();
		logic [PIX_W-1:0] p;
		case ($urandom_range(3))
			0, 1: p = PIX_W'($urandom_range(255));
			2: p = $urandom_range(1) ? 8'hFF : 8'h00;
			default: p = last_pixel + PIX_W'($urandom_range(16)) - 8'd8;
		endcase
		last_pixel = p;
		return p;
	endfunction

	task automatic predict_gradient(input logic [PIX_W-1:0] p, output bit produced,
		output sobel_result_t res);
		int unsigned w, h, c, r;
		int gx, gy;
		logic [PIX_W-1:0] above, two_above;
		w = clamp_dim(width_reg, MAX_WIDTH);
		h = clamp_dim(height_reg, MAX_HEIGHT);
		c = (col_pos >= w) ? 0 : col_pos;
		r = (row_pos >= h) ? 0 : row_pos;
		two_above = row_two_above_mem[c];
		above = row_above_mem[c];
		produced = 1'b0;
		res = '0;
		if (r >= 2 && c >= 2) begin
			gx = (int'(two_above) + 2 * int'(above) + int'(p))
				- (int'(win_old[0]) + 2 * int'(win_old[1]) + int'(win_old[2]));
			gy = (int'(win_old[2]) + 2 * int'(win_new[2]) + int'(p))
				- (int'(win_old[0]) + 2 * int'(win_new[0]) + int'(two_above));
			res.magnitude = root_floor_sat(gx * gx + gy * gy);
			res.frame_last = (r == h - 1 && c == w - 1);
			produced = 1'b1;
		end
		row_two_above_mem[c] = above;
		row_above_mem[c] = p;
		win_old = win_new;
		win_new[0] = two_above;
		win_new[1] = above;
		win_new[2] = p;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		col_pos = c;
		row_pos = r;
	endtask

	// drive one pixel request, wait for it to be taken, then record the result
	task automatic feed_pixel(input logic [PIX_W-1:0] p, input bit typed,
		input sobel_result_t typed_res);
		bit produced;
		sobel_result_t res;
		while ($urandom_range(99) < idle_pct) begin
			pix_bus.valid <= 1'b0;
			@(posedge clk);
		end
		pix_bus.valid <= 1'b1;
		pix_bus.pixel <= p;
		do @(posedge clk); while (!pix_bus.ready);
		pixels_sent++;
		predict_gradient(p, produced, res);
		if (produced) expected_results.push_back(typed ? typed_res : res);
	endtask

	task automatic drain_results();
		pix_bus.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_register(input sem_pkg::cfg_reg_t sel, input logic [CFG_W-1:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (sel == sem_pkg::REG_WIDTH) width_reg = v;
		else height_reg = v;
		col_pos = 0;
		row_pos = 0;
		settings_used++;
	endtask

	// receiver: random stalls, plus an occasional long hold-off
	initial begin
		res_bus.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles != 0) begin
				res_bus.ready <= 1'b0;
				repeat (hold_off_cycles) @(posedge clk);
				hold_off_cycles = 0;
			end
			res_bus.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		sobel_result_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			if (expected_results.size() == 0) begin
				error_count++;
				$error("unexpected result: magnitude %0d frame_last %0b",
					res_bus.magnitude, res_bus.frame_last);
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (res_bus.magnitude !== want.magnitude) begin
					error_count++;
					$error("magnitude: expected %0d, got %0d", want.magnitude, res_bus.magnitude);
				end
				if (res_bus.frame_last !== want.frame_last) begin
					error_count++;
					$error("frame_last: expected %0b, got %0b", want.frame_last,
						res_bus.frame_last);
				end
			end
		end
	end

	initial begin
		int w_sel, h_sel, n_items;
		sobel_result_t typed_res;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sem_pkg::REG_WIDTH;
		cfg_data = '0;
		pix_bus.valid = 1'b0;
		pix_bus.pixel = '0;
		error_count = 0;
		pixels_sent = 0;
		results_checked = 0;
		settings_used = 0;
		cycle_count = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_off_cycles = 0;
		last_pixel = 8'd128;
		width_reg = sem_pkg::WIDTH_RST;
		height_reg = sem_pkg::HEIGHT_RST;
		for (int i = 0; i < MAX_WIDTH; i++) begin
			row_above_mem[i] = '0;
			row_two_above_mem[i] = '0;
		end
		for (int i = 0; i < 3; i++) begin
			win_old[i] = '0;
			win_new[i] = '0;
		end
		col_pos = 0;
		row_pos = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// default 640x480 frame: first row only, so no results yet
		for (int i = 0; i < 40; i++) feed_pixel(pick_pixel(), 1'b0, '0);

		for (int i = 0; i < NUM_ROWS; i++) begin
			if (DIRECTED_ROWS[i].is_write) begin
				write_register(DIRECTED_ROWS[i].reg_sel, DIRECTED_ROWS[i].value);
			end else begin
				typed_res.magnitude = DIRECTED_ROWS[i].magnitude;
				typed_res.frame_last = DIRECTED_ROWS[i].frame_last;
				feed_pixel(DIRECTED_ROWS[i].value[PIX_W-1:0], DIRECTED_ROWS[i].typed, typed_res);
			end
		end

		// random frame sizes, cycling through the idling modes
		for (int ph = 0; ph < 12; ph++) begin
			w_sel = ($urandom_range(3) == 0) ? $urandom_range(2) : $urandom_range(3, 20);
			h_sel = ($urandom_range(3) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
			write_register(sem_pkg::REG_WIDTH, CFG_W'(w_sel));
			if (ph < 2 || $urandom_range(3) != 0)
				write_register(sem_pkg::REG_HEIGHT, CFG_W'(h_sel));
			case (ph % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 77; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 77; end
				default: begin idle_pct = 25; stall_pct = 25; end
			endcase
			n_items = $urandom_range(40, 70);
			for (int i = 0; i < n_items; i++) feed_pixel(pick_pixel(), 1'b0, '0);
		end

		// long receiver hold-off with dense results so the input backs up
		idle_pct = 0;
		stall_pct = 0;
		write_register(sem_pkg::REG_WIDTH, 11'd4);
		write_register(sem_pkg::REG_HEIGHT, 11'd20);
		hold_off_cycles = 300;
		for (int i = 0; i < 200; i++) feed_pixel(pick_pixel(), 1'b0, '0);

		// widest frame (2047 clamps to 1024), then tallest (2047 clamps to 1024)
		write_register(sem_pkg::REG_WIDTH, 11'd2047);
		write_register(sem_pkg::REG_HEIGHT, 11'd3);
		for (int i = 0; i < 150; i++) feed_pixel(pick_pixel(), 1'b0, '0);
		write_register(sem_pkg::REG_WIDTH, 11'd3);
		write_register(sem_pkg::REG_HEIGHT, 11'd2047);
		for (int i = 0; i < 3 * 90; i++) feed_pixel(pick_pixel(), 1'b0, '0);

		drain_results();
		$display("Sent %0d pixel requests over %0d register settings", pixels_sent,
			settings_used);
		$display("Checked %0d magnitude results, including clamped and saturated cases",
			results_checked);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
